@@ sv/mat_pkg.sv @@
`default_nettype none

package mat_pkg;

    // Grid and ant limits.
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int MAX_ANT_COUNT = 256;

    // Columns and rows that the 8-bit coordinates can reach.
    localparam int LIM_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int LIM_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // Cell memory geometry, row-major with a row pitch of MAX_WIDTH.
    localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int ANT_AW  = (MAX_ANT_COUNT > 1) ? $clog2(MAX_ANT_COUNT) : 1;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int NUM_W     = 9;
    localparam int COORD_W   = 8;
    localparam int HD_W      = 2;
    localparam int COLOR_W   = 8;
    localparam int RULE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int DIM_W     = 9;
    localparam int REM_W     = 5;
    localparam int RPOS_W    = 5;
    localparam int BIT_IDX_W = $clog2(COLOR_W);

    // Configuration port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Operations.
    localparam logic [OP_W-1:0] OP_PLACE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // Headings.
    localparam logic [HD_W-1:0] HD_YINC = 2'd0;
    localparam logic [HD_W-1:0] HD_XDEC = 2'd1;
    localparam logic [HD_W-1:0] HD_YDEC = 2'd2;
    localparam logic [HD_W-1:0] HD_XINC = 2'd3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ANT_TYPE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RULE_BITS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RULE_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANT_COUNT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd6;

    // One entry of the ant table.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [HD_W-1:0]    hd;
    } t_ant_rec;

    // Configuration after range limiting.
    typedef struct packed {
        logic               ant_type;
        logic               wrap;
        logic [RULE_W-1:0]  rule_bits;
        logic [LEN_W-1:0]   len;
        logic [ANT_AW-1:0]  last_ant;
        logic [COORD_W-1:0] last_col;
        logic [COORD_W-1:0] last_row;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic place_wr;
        logic start_gen;
        logic ant_lat;
        logic rd_issue;
        logic rd_lat;
        logic cell_lat;
        logic mod_step;
        logic ant_upd;
        logic rule_adv;
        logic clear_wr;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            halted;
        logic            halt_now;
        logic            last_ant;
        logic            mod_done;
        logic            clear_done;
        logic            ant_type;
        logic            out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ sv/mat_ifs.sv @@
`default_nettype none

// Item channel: one beat is one place, advance or read request.
interface mat_in_if;
    logic                          valid;
    logic                          ready;
    logic [mat_pkg::OP_W-1:0]      operation;
    logic [mat_pkg::NUM_W-1:0]     ant_number;
    logic [mat_pkg::COORD_W-1:0]   x_pos;
    logic [mat_pkg::COORD_W-1:0]   y_pos;
    logic [mat_pkg::HD_W-1:0]      heading;

    modport source (output valid, operation, ant_number, x_pos, y_pos, heading,
                    input ready);
    modport sink (input valid, operation, ant_number, x_pos, y_pos, heading,
                  output ready);
endinterface

// Result channel: one beat per item.
interface mat_out_if;
    logic                          valid;
    logic                          ready;
    logic [mat_pkg::COLOR_W-1:0]   cell_color;
    logic                          halted;

    modport source (output valid, cell_color, halted, input ready);
    modport sink (input valid, cell_color, halted, output ready);
endinterface

`default_nettype wire

@@ sv/multi_ant_turmite_step.sv @@
`default_nettype none

// Channel    Direction  Beat contents
// i_item     in         operation, ant_number, x_pos, y_pos, heading
// o_result   out        cell_color, halted
// APB        in/out     register writes and reads, 4-byte spacing
//
// One item at a time: a new item is accepted only after the last result is loaded.
// In an advance, each ant in turn waits on the ant table read, the cell read and,
// in type 0, the 8-step colour remainder unit before its update cycle.
// After reset the cell memory is swept to zero, one cell a cycle,
// with the item channel not ready. The result register holds a beat until taken.
module multi_ant_turmite_step (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    mat_in_if.sink                       i_item,
    mat_out_if.source                    o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [mat_pkg::PADDR_W-1:0]  paddr,
    input  wire  [mat_pkg::PDATA_W-1:0]  pwdata,
    output logic [mat_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    mat_pkg::t_cfg    w_cfg;
    mat_pkg::t_dp_cmd w_cmd;
    mat_pkg::t_dp_sts w_sts;
    logic             w_item_ready;
    logic             w_res_valid;
    logic [mat_pkg::COLOR_W-1:0] w_cell_color;
    logic             w_halted;

    // Configuration registers.
    mat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    mat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (w_item_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // Datapath and memories.
    mat_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg        (w_cfg),
        .i_operation  (i_item.operation),
        .i_ant_number (i_item.ant_number),
        .i_x_pos      (i_item.x_pos),
        .i_y_pos      (i_item.y_pos),
        .i_heading    (i_item.heading),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (o_result.ready),
        .o_cell_color (w_cell_color),
        .o_halted     (w_halted)
    );

    assign i_item.ready        = w_item_ready;
    assign o_result.valid      = w_res_valid;
    assign o_result.cell_color = w_cell_color;
    assign o_result.halted     = w_halted;

`ifndef NO_ASSERTIONS
    // The halt flag only clears through reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(w_sts.halted))
        else $error("halt flag cleared without reset");

    // An accepted item closes the input until its result is handed off.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && w_item_ready) |=> !w_item_ready)
        else $error("input still ready after accepting an item");

    // A result is only loaded when the result register is free.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_sts.out_free)
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

@@ sv/mat_ram.sv @@
`default_nettype none

// Simple dual-port RAM with a registered read.
module mat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [AW-1:0]    i_waddr,
    input  wire  [WIDTH-1:0] i_wdata,
    input  wire  [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/mat_regs.sv @@
`default_nettype none

// Configuration registers behind the APB-style port, with range limiting.
module mat_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [mat_pkg::PADDR_W-1:0]  paddr,
    input  wire  [mat_pkg::PDATA_W-1:0]  pwdata,
    output logic [mat_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output mat_pkg::t_cfg                o_cfg
);

    logic                            r_ant_type;
    logic                            r_wrap;
    logic [mat_pkg::RULE_W-1:0]      r_rule_bits;
    logic [mat_pkg::LEN_W-1:0]       r_rule_len;
    logic [mat_pkg::DIM_W-1:0]       r_ant_cnt;
    logic [mat_pkg::DIM_W-1:0]       r_grid_w;
    logic [mat_pkg::DIM_W-1:0]       r_grid_h;
    logic                            w_wr;
    logic [mat_pkg::REG_IDX_W-1:0]   w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[mat_pkg::PADDR_W-1:2];
    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant_type  <= 1'b0;
            r_wrap      <= 1'b0;
            r_rule_bits <= mat_pkg::RULE_W'(1);
            r_rule_len  <= mat_pkg::LEN_W'(2);
            r_ant_cnt   <= mat_pkg::DIM_W'(1);
            r_grid_w    <= mat_pkg::DIM_W'(256);
            r_grid_h    <= mat_pkg::DIM_W'(256);
        end else if (w_wr) begin
            case (w_idx)
                mat_pkg::REG_ANT_TYPE:    r_ant_type  <= pwdata[0];
                mat_pkg::REG_WRAP_ENABLE: r_wrap      <= pwdata[0];
                mat_pkg::REG_RULE_BITS:   r_rule_bits <= pwdata[mat_pkg::RULE_W-1:0];
                mat_pkg::REG_RULE_LENGTH: r_rule_len  <= pwdata[mat_pkg::LEN_W-1:0];
                mat_pkg::REG_ANT_COUNT:   r_ant_cnt   <= pwdata[mat_pkg::DIM_W-1:0];
                mat_pkg::REG_GRID_WIDTH:  r_grid_w    <= pwdata[mat_pkg::DIM_W-1:0];
                mat_pkg::REG_GRID_HEIGHT: r_grid_h    <= pwdata[mat_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the raw register values.
    always_comb begin
        case (w_idx)
            mat_pkg::REG_ANT_TYPE:    prdata = mat_pkg::PDATA_W'(r_ant_type);
            mat_pkg::REG_WRAP_ENABLE: prdata = mat_pkg::PDATA_W'(r_wrap);
            mat_pkg::REG_RULE_BITS:   prdata = mat_pkg::PDATA_W'(r_rule_bits);
            mat_pkg::REG_RULE_LENGTH: prdata = mat_pkg::PDATA_W'(r_rule_len);
            mat_pkg::REG_ANT_COUNT:   prdata = mat_pkg::PDATA_W'(r_ant_cnt);
            mat_pkg::REG_GRID_WIDTH:  prdata = mat_pkg::PDATA_W'(r_grid_w);
            mat_pkg::REG_GRID_HEIGHT: prdata = mat_pkg::PDATA_W'(r_grid_h);
            default:                  prdata = '0;
        endcase
    end

    // Limit the rule length, ant count and grid size to their working ranges.
    always_comb begin
        o_cfg.ant_type  = r_ant_type;
        o_cfg.wrap      = r_wrap;
        o_cfg.rule_bits = r_rule_bits;

        if (r_rule_len == '0) begin
            o_cfg.len = mat_pkg::LEN_W'(1);
        end else if (r_rule_len > mat_pkg::LEN_W'(32)) begin
            o_cfg.len = mat_pkg::LEN_W'(32);
        end else begin
            o_cfg.len = r_rule_len;
        end

        if (r_ant_cnt == '0) begin
            o_cfg.last_ant = '0;
        end else if (r_ant_cnt > mat_pkg::DIM_W'(mat_pkg::MAX_ANT_COUNT)) begin
            o_cfg.last_ant = mat_pkg::ANT_AW'(mat_pkg::MAX_ANT_COUNT - 1);
        end else begin
            o_cfg.last_ant = mat_pkg::ANT_AW'(r_ant_cnt - mat_pkg::DIM_W'(1));
        end

        if (r_grid_w == '0) begin
            o_cfg.last_col = '0;
        end else if (r_grid_w > mat_pkg::DIM_W'(mat_pkg::LIM_W)) begin
            o_cfg.last_col = mat_pkg::COORD_W'(mat_pkg::LIM_W - 1);
        end else begin
            o_cfg.last_col = mat_pkg::COORD_W'(r_grid_w - mat_pkg::DIM_W'(1));
        end

        if (r_grid_h == '0) begin
            o_cfg.last_row = '0;
        end else if (r_grid_h > mat_pkg::DIM_W'(mat_pkg::LIM_H)) begin
            o_cfg.last_row = mat_pkg::COORD_W'(mat_pkg::LIM_H - 1);
        end else begin
            o_cfg.last_row = mat_pkg::COORD_W'(r_grid_h - mat_pkg::DIM_W'(1));
        end
    end

endmodule

`default_nettype wire

@@ sv/mat_ctrl.sv @@
`default_nettype none

// Sequencer: clearing pass, item decode, per-ant walk and result hand-off.
module mat_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_item_valid,
    output logic               o_item_ready,
    input  wire mat_pkg::t_dp_sts i_sts,
    output mat_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_ANT_RD  = 4'd3;
    localparam logic [3:0] S_ANT_WT  = 4'd4;
    localparam logic [3:0] S_CELL_WT = 4'd5;
    localparam logic [3:0] S_MOD     = 4'd6;
    localparam logic [3:0] S_UPD     = 4'd7;
    localparam logic [3:0] S_RD_WAIT = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    mat_pkg::OP_PLACE: begin
                        o_cmd.place_wr = 1'b1;
                        n_state        = S_DONE;
                    end
                    mat_pkg::OP_ADVANCE: begin
                        if (i_sts.halted) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.start_gen = 1'b1;
                            n_state         = S_ANT_RD;
                        end
                    end
                    mat_pkg::OP_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RD_WAIT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ANT_RD: begin
                n_state = S_ANT_WT;
            end
            S_ANT_WT: begin
                o_cmd.ant_lat = 1'b1;
                n_state       = S_CELL_WT;
            end
            S_CELL_WT: begin
                o_cmd.cell_lat = 1'b1;
                n_state        = i_sts.ant_type ? S_UPD : S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.ant_upd = 1'b1;
                if (i_sts.halt_now) begin
                    n_state = S_DONE;
                end else if (i_sts.last_ant) begin
                    o_cmd.rule_adv = i_sts.ant_type;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_ANT_RD;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_lat = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/mat_dp.sv @@
`default_nettype none

// Datapath: ant table, cell memory, remainder unit, ant update and result register.
module mat_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire mat_pkg::t_dp_cmd         i_cmd,
    output mat_pkg::t_dp_sts              o_sts,
    input  wire mat_pkg::t_cfg            i_cfg,
    input  wire  [mat_pkg::OP_W-1:0]      i_operation,
    input  wire  [mat_pkg::NUM_W-1:0]     i_ant_number,
    input  wire  [mat_pkg::COORD_W-1:0]   i_x_pos,
    input  wire  [mat_pkg::COORD_W-1:0]   i_y_pos,
    input  wire  [mat_pkg::HD_W-1:0]      i_heading,
    output logic                          o_res_valid,
    input  wire                           i_res_ready,
    output logic [mat_pkg::COLOR_W-1:0]   o_cell_color,
    output logic                          o_halted
);

    // Item registers.
    logic [mat_pkg::OP_W-1:0]      r_op;
    logic [mat_pkg::NUM_W-1:0]     r_num;
    logic [mat_pkg::COORD_W-1:0]   r_ix;
    logic [mat_pkg::COORD_W-1:0]   r_iy;
    logic [mat_pkg::HD_W-1:0]      r_ihd;

    // Working registers of the current ant.
    logic [mat_pkg::ANT_AW-1:0]    r_idx;
    logic [mat_pkg::COORD_W-1:0]   r_x;
    logic [mat_pkg::COORD_W-1:0]   r_y;
    logic [mat_pkg::HD_W-1:0]      r_d;
    logic [mat_pkg::COLOR_W-1:0]   r_c;
    logic [mat_pkg::REM_W-1:0]     r_rem;
    logic [mat_pkg::BIT_IDX_W-1:0] r_mcnt;
    logic [mat_pkg::COLOR_W-1:0]   r_color;

    // Control state.
    logic                          r_halt;
    logic [mat_pkg::RPOS_W-1:0]    r_rpos;
    logic [mat_pkg::CELL_AW-1:0]   r_clr_addr;
    logic                          r_ovalid;
    logic [mat_pkg::COLOR_W-1:0]   r_out_color;
    logic                          r_out_halt;

    // Memory ports.
    logic [$bits(mat_pkg::t_ant_rec)-1:0] w_ant_rdata;
    mat_pkg::t_ant_rec                    w_ant_rd;
    mat_pkg::t_ant_rec                    w_ant_wd;
    logic                                 w_ant_we;
    logic [mat_pkg::ANT_AW-1:0]           w_ant_waddr;
    logic [mat_pkg::COLOR_W-1:0]          w_cell_rd;
    logic                                 w_cell_we;
    logic [mat_pkg::CELL_AW-1:0]          w_cell_waddr;
    logic [mat_pkg::COLOR_W-1:0]          w_cell_wdata;
    logic [mat_pkg::CELL_AW-1:0]          w_cell_raddr;

    // Combinational helpers.
    logic [mat_pkg::COORD_W-1:0]   w_ax;
    logic [mat_pkg::COORD_W-1:0]   w_ay;
    logic [mat_pkg::COORD_W-1:0]   w_px;
    logic [mat_pkg::COORD_W-1:0]   w_py;
    logic                          w_place_ok;
    logic [mat_pkg::LEN_W-1:0]     w_rem_sh;
    logic [mat_pkg::REM_W-1:0]     w_rem_next;
    logic [mat_pkg::NUM_W-1:0]     w_ant_num;
    logic                          w_t1_right;
    logic                          w_left;
    logic [mat_pkg::COLOR_W-1:0]   w_new_color;
    logic [mat_pkg::HD_W-1:0]      w_nd;
    logic [mat_pkg::COORD_W-1:0]   w_nx;
    logic [mat_pkg::COORD_W-1:0]   w_ny;
    logic                          w_border;
    logic                          w_halt_now;
    logic                          w_in_range;

    function automatic logic [mat_pkg::CELL_AW-1:0] cell_addr(
        input logic [mat_pkg::COORD_W-1:0] x,
        input logic [mat_pkg::COORD_W-1:0] y
    );
        cell_addr = mat_pkg::CELL_AW'(y) * mat_pkg::CELL_AW'(mat_pkg::MAX_WIDTH)
                  + mat_pkg::CELL_AW'(x);
    endfunction

    // Ant table: column, row and heading of each ant, indexed by number minus one.
    mat_ram #(
        .WIDTH ($bits(mat_pkg::t_ant_rec)),
        .DEPTH (mat_pkg::MAX_ANT_COUNT)
    ) u_ant_ram (
        .i_clk   (i_clk),
        .i_we    (w_ant_we),
        .i_waddr (w_ant_waddr),
        .i_wdata (w_ant_wd),
        .i_raddr (r_idx),
        .o_rdata (w_ant_rdata)
    );

    assign w_ant_rd = mat_pkg::t_ant_rec'(w_ant_rdata);

    // Cell memory, swept to zero after reset.
    mat_ram #(
        .WIDTH (mat_pkg::COLOR_W),
        .DEPTH (mat_pkg::CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rd)
    );

    // Ant position pulled into the grid in use.
    assign w_ax = (w_ant_rd.col > i_cfg.last_col) ? i_cfg.last_col : w_ant_rd.col;
    assign w_ay = (w_ant_rd.row > i_cfg.last_row) ? i_cfg.last_row : w_ant_rd.row;

    // Placement coordinates pulled into the grid in use.
    assign w_px = (r_ix > i_cfg.last_col) ? i_cfg.last_col : r_ix;
    assign w_py = (r_iy > i_cfg.last_row) ? i_cfg.last_row : r_iy;
    assign w_place_ok = (r_num != '0) && (r_num <= mat_pkg::NUM_W'(mat_pkg::MAX_ANT_COUNT));

    assign w_in_range = (r_ix <= i_cfg.last_col) && (r_iy <= i_cfg.last_row);

    assign w_cell_raddr = i_cmd.rd_issue ? cell_addr(r_ix, r_iy) : cell_addr(w_ax, w_ay);

    // One restoring step of colour modulo rule length, most significant bit first.
    assign w_rem_sh   = {r_rem, r_c[r_mcnt]};
    assign w_rem_next = (w_rem_sh >= i_cfg.len) ? mat_pkg::REM_W'(w_rem_sh - i_cfg.len)
                                                : mat_pkg::REM_W'(w_rem_sh);

    // Turn decision and new colour.
    assign w_ant_num  = mat_pkg::NUM_W'(r_idx) + mat_pkg::NUM_W'(1);
    assign w_t1_right = (r_c != '0) && i_cfg.rule_bits[r_rpos];

    always_comb begin
        if (i_cfg.ant_type) begin
            w_left      = !w_t1_right;
            w_new_color = w_t1_right ? '0 : w_ant_num[mat_pkg::COLOR_W-1:0];
        end else begin
            w_left      = i_cfg.rule_bits[r_rem];
            w_new_color = r_c + mat_pkg::COLOR_W'(1);
        end
    end

    assign w_nd = w_left ? (r_d + mat_pkg::HD_W'(1)) : (r_d - mat_pkg::HD_W'(1));

    // Border test and step with wrap-around.
    always_comb begin
        w_nx = r_x;
        w_ny = r_y;
        case (w_nd)
            mat_pkg::HD_YINC: begin
                w_border = (r_y == i_cfg.last_row);
                w_ny     = w_border ? '0 : r_y + mat_pkg::COORD_W'(1);
            end
            mat_pkg::HD_XDEC: begin
                w_border = (r_x == '0);
                w_nx     = w_border ? i_cfg.last_col : r_x - mat_pkg::COORD_W'(1);
            end
            mat_pkg::HD_YDEC: begin
                w_border = (r_y == '0);
                w_ny     = w_border ? i_cfg.last_row : r_y - mat_pkg::COORD_W'(1);
            end
            default: begin
                w_border = (r_x == i_cfg.last_col);
                w_nx     = w_border ? '0 : r_x + mat_pkg::COORD_W'(1);
            end
        endcase
    end

    assign w_halt_now = !i_cfg.wrap && w_border;

    // Ant table write: placement or end of a move.
    always_comb begin
        if (i_cmd.place_wr) begin
            w_ant_we    = w_place_ok;
            w_ant_waddr = mat_pkg::ANT_AW'(r_num - mat_pkg::NUM_W'(1));
            w_ant_wd    = '{col: w_px, row: w_py, hd: r_ihd};
        end else begin
            w_ant_we    = i_cmd.ant_upd && !w_halt_now;
            w_ant_waddr = r_idx;
            w_ant_wd    = '{col: w_nx, row: w_ny, hd: w_nd};
        end
    end

    // Cell write: clearing pass or repaint.
    assign w_cell_we    = i_cmd.clear_wr || i_cmd.ant_upd;
    assign w_cell_waddr = i_cmd.clear_wr ? r_clr_addr : cell_addr(r_x, r_y);
    assign w_cell_wdata = i_cmd.clear_wr ? '0 : w_new_color;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt     <= 1'b0;
            r_rpos     <= '0;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.ant_upd && w_halt_now) begin
                r_halt <= 1'b1;
            end
            if (i_cmd.rule_adv) begin
                r_rpos <= r_rpos + mat_pkg::RPOS_W'(1);
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + mat_pkg::CELL_AW'(1);
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_operation;
            r_num   <= i_ant_number;
            r_ix    <= i_x_pos;
            r_iy    <= i_y_pos;
            r_ihd   <= i_heading;
            r_color <= '0;
        end
        if (i_cmd.rd_lat) begin
            r_color <= w_in_range ? w_cell_rd : '0;
        end
        if (i_cmd.start_gen) begin
            r_idx <= i_cfg.last_ant;
        end
        if (i_cmd.ant_upd) begin
            r_idx <= r_idx - mat_pkg::ANT_AW'(1);
        end
        if (i_cmd.ant_lat) begin
            r_x <= w_ax;
            r_y <= w_ay;
            r_d <= w_ant_rd.hd;
        end
        if (i_cmd.cell_lat) begin
            r_c    <= w_cell_rd;
            r_rem  <= '0;
            r_mcnt <= mat_pkg::BIT_IDX_W'(mat_pkg::COLOR_W - 1);
        end
        if (i_cmd.mod_step) begin
            r_rem  <= w_rem_next;
            r_mcnt <= r_mcnt - mat_pkg::BIT_IDX_W'(1);
        end
        if (i_cmd.push) begin
            r_out_color <= r_color;
            r_out_halt  <= r_halt;
        end
    end

    // Status to the controller.
    assign o_sts.op         = r_op;
    assign o_sts.halted     = r_halt;
    assign o_sts.halt_now   = w_halt_now;
    assign o_sts.last_ant   = (r_idx == '0);
    assign o_sts.mod_done   = (r_mcnt == '0);
    assign o_sts.clear_done = (r_clr_addr == mat_pkg::CELL_AW'(mat_pkg::CELLS - 1));
    assign o_sts.ant_type   = i_cfg.ant_type;
    assign o_sts.out_free   = !r_ovalid || i_res_ready;

    assign o_res_valid  = r_ovalid;
    assign o_cell_color = r_out_color;
    assign o_halted     = r_out_halt;

endmodule

`default_nettype wire

@@ tb/sv/tb_multi_ant_turmite_step.sv @@
`timescale 1ns / 100ps

module tb_multi_ant_turmite_step;
    import mat_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int QUIET_LIMIT = 250_000;
    localparam int LONG_HOLD   = 300;
    localparam int PROBE_N     = 21;
    localparam int RECENT_N    = 64;

    // One item beat as offered on the item channel.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NUM_W-1:0]   num;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [HD_W-1:0]    hd;
    } t_item;

    // One result beat: the cell colour and the halt status.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               halted;
    } t_report;

    // A directed row; fixed rows carry their own answer.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NUM_W-1:0]   num;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [HD_W-1:0]    hd;
        logic               fixed;
        logic [COLOR_W-1:0] color;
        logic               halted;
    } t_probe;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    mat_in_if  item_ch ();
    mat_out_if result_ch ();

    multi_ant_turmite_step i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the block's registers, as last written.
    logic               cfg_ant_type = 1'b0;
    logic               cfg_wrap     = 1'b0;
    logic [RULE_W-1:0]  cfg_rule     = 32'd1;
    logic [LEN_W-1:0]   cfg_rule_len = 6'd2;
    logic [DIM_W-1:0]   cfg_ants     = 9'd1;
    logic [DIM_W-1:0]   cfg_cols     = 9'd256;
    logic [DIM_W-1:0]   cfg_rows     = 9'd256;

    // Shadow of the grid, the ant table and the generation state.
    logic [COLOR_W-1:0] cell_mem [0:CELLS-1] = '{default: '0};
    logic [COORD_W-1:0] ant_col [1:MAX_ANT_COUNT];
    logic [COORD_W-1:0] ant_row [1:MAX_ANT_COUNT];
    logic [HD_W-1:0]    ant_hd [1:MAX_ANT_COUNT];
    bit                 ant_placed [1:MAX_ANT_COUNT] = '{default: 1'b0};
    logic               halt_seen = 1'b0;
    logic [RPOS_W-1:0]  rule_pos = '0;

    // Recently painted cells, so that reads find colours worth checking.
    int unsigned        recent_cells [0:RECENT_N-1];
    int unsigned        recent_total = 0;

    t_report            awaited_reports [$];
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    int                 hold_orders = 0;
    int                 holds_served = 0;
    int                 stall_left = 0;
    bit                 calm = 1'b0;

    t_probe             probe_rows [0:PROBE_N-1];

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned grid_cols();
        return clamp_to(cfg_cols, 1, LIM_W);
    endfunction

    function automatic int unsigned grid_rows();
        return clamp_to(cfg_rows, 1, LIM_H);
    endfunction

    function automatic int unsigned ants_in_play();
        return clamp_to(cfg_ants, 1, MAX_ANT_COUNT);
    endfunction

    // One generation: ants move from the highest number down to 1.
    function automatic void move_all_ants();
        int unsigned w, h, len, x, y, idx, c;
        int a;
        logic [HD_W-1:0] d;
        bit turn_left;
        w = grid_cols();
        h = grid_rows();
        len = clamp_to(cfg_rule_len, 1, 32);
        if (halt_seen) return;
        for (a = ants_in_play(); a >= 1; a--) begin
            x = ant_col[a];
            y = ant_row[a];
            d = ant_hd[a];
            if (x >= w) x = w - 1;
            if (y >= h) y = h - 1;
            idx = y * MAX_WIDTH + x;
            c = cell_mem[idx];
            if (cfg_ant_type == 1'b0) begin
                turn_left = cfg_rule[c % len];
                cell_mem[idx] = COLOR_W'(c + 1);
            end else if (c != 0 && cfg_rule[rule_pos]) begin
                turn_left = 1'b0;
                cell_mem[idx] = '0;
            end else begin
                turn_left = 1'b1;
                cell_mem[idx] = COLOR_W'(a);
            end
            recent_cells[recent_total % RECENT_N] = idx;
            recent_total++;
            d = d + (turn_left ? 2'd1 : 2'd3);

            // Without wrapping, the first ant to meet the border stops the whole grid.
            if (!cfg_wrap && ((d == HD_YINC && y == h - 1) || (d == HD_XDEC && x == 0) ||
                              (d == HD_YDEC && y == 0) || (d == HD_XINC && x == w - 1))) begin
                halt_seen = 1'b1;
                return;
            end
            case (d)
                HD_YINC: y = (y + 1 >= h) ? 0 : y + 1;
                HD_XDEC: x = (x == 0) ? w - 1 : x - 1;
                HD_YDEC: y = (y == 0) ? h - 1 : y - 1;
                default: x = (x + 1 >= w) ? 0 : x + 1;
            endcase
            ant_col[a] = COORD_W'(x);
            ant_row[a] = COORD_W'(y);
            ant_hd[a] = d;
        end
        if (cfg_ant_type) rule_pos = rule_pos + 1'b1;
    endfunction

    // Applies one accepted item to the shadow state and returns its result beat.
    function automatic t_report turmite_step(input t_item it);
        t_report rep;
        int unsigned w, h;
        rep = '0;
        w = grid_cols();
        h = grid_rows();
        case (it.op)
            OP_PLACE: begin
                if (it.num >= 1 && it.num <= MAX_ANT_COUNT) begin
                    ant_col[it.num] = (it.x >= w) ? COORD_W'(w - 1) : it.x;
                    ant_row[it.num] = (it.y >= h) ? COORD_W'(h - 1) : it.y;
                    ant_hd[it.num] = it.hd;
                    ant_placed[it.num] = 1'b1;
                end
            end
            OP_ADVANCE: move_all_ants();
            OP_READ: begin
                if (it.x < w && it.y < h) rep.color = cell_mem[it.y * MAX_WIDTH + it.x];
            end
            default: ;
        endcase
        rep.halted = halt_seen;
        return rep;
    endfunction

    // Random item. Unplaced ants are placed before any generation may run.
    function automatic t_item pick_item();
        t_item it;
        int unsigned w, h, n, roll, idx;
        int k;
        bit pending;
        w = grid_cols();
        h = grid_rows();
        n = ants_in_play();
        it.op = OP_ADVANCE;
        it.num = NUM_W'($urandom_range(1, n));
        it.x = COORD_W'($urandom_range(0, w - 1));
        it.y = COORD_W'($urandom_range(0, h - 1));
        it.hd = HD_W'($urandom_range(0, 3));
        pending = 1'b0;
        for (k = n; k >= 1; k--) begin
            if (!ant_placed[k]) begin
                pending = 1'b1;
                it.num = NUM_W'(k);
            end
        end
        roll = $urandom_range(0, 99);
        if (pending && roll < 85) begin
            it.op = OP_PLACE;
        end else if (roll < 45) begin
            it.op = OP_ADVANCE;
            it.num = NUM_W'($urandom_range(0, 511));
        end else if (roll < 75) begin
            it.op = OP_READ;
            it.num = NUM_W'($urandom_range(0, 511));
            roll = $urandom_range(0, 9);
            if (roll < 5 && recent_total != 0) begin
                idx = recent_cells[$urandom_range(0, clamp_to(recent_total, 1, RECENT_N) - 1)];
                it.x = COORD_W'(idx % MAX_WIDTH);
                it.y = COORD_W'(idx / MAX_WIDTH);
            end else if (roll >= 8) begin
                it.x = COORD_W'($urandom_range(0, 255));
                it.y = COORD_W'($urandom_range(0, 255));
            end
        end else if (roll < 94) begin
            it.op = OP_PLACE;
            if ($urandom_range(0, 7) == 0) it.num = NUM_W'($urandom_range(1, MAX_ANT_COUNT));
            if ($urandom_range(0, 4) == 0) begin
                it.x = COORD_W'($urandom_range(0, 255));
                it.y = COORD_W'($urandom_range(0, 255));
            end
        end else begin
            // Beats the block must ignore.
            it.x = COORD_W'($urandom_range(0, 255));
            it.y = COORD_W'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: begin
                    it.op = OP_NONE;
                    it.num = NUM_W'($urandom_range(0, 511));
                end
                1: begin
                    it.op = OP_PLACE;
                    it.num = '0;
                end
                default: begin
                    it.op = OP_PLACE;
                    it.num = NUM_W'($urandom_range(MAX_ANT_COUNT + 1, 511));
                end
            endcase
        end
        return it;
    endfunction

    // Offers one beat and records its result once the block takes it.
    task automatic offer_item(input t_item it, input bit fixed, input t_report fixed_rep);
        t_report rep;
        item_ch.valid <= 1'b1;
        item_ch.operation <= it.op;
        item_ch.ant_number <= it.num;
        item_ch.x_pos <= it.x;
        item_ch.y_pos <= it.y;
        item_ch.heading <= it.hd;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        rep = turmite_step(it);
        awaited_reports.push_back(fixed ? fixed_rep : rep);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 9) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every result beat has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup and access cycle of one write; the caller closes the transfer.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_ANT_TYPE:    cfg_ant_type = val[0];
            REG_WRAP_ENABLE: cfg_wrap = val[0];
            REG_RULE_BITS:   cfg_rule = val;
            REG_RULE_LENGTH: cfg_rule_len = val[LEN_W-1:0];
            REG_ANT_COUNT:   cfg_ants = val[DIM_W-1:0];
            REG_GRID_WIDTH:  cfg_cols = val[DIM_W-1:0];
            default:         cfg_rows = val[DIM_W-1:0];
        endcase
    endtask

    task automatic configure(input logic kind, input logic wrap, input logic [31:0] rule,
                             input logic [31:0] len, input logic [31:0] ants,
                             input logic [31:0] cols, input logic [31:0] rows);
        drain_results();
        reg_write(REG_ANT_TYPE, kind);
        reg_write(REG_WRAP_ENABLE, wrap);
        reg_write(REG_RULE_BITS, rule);
        reg_write(REG_RULE_LENGTH, len);
        reg_write(REG_ANT_COUNT, ants);
        reg_write(REG_GRID_WIDTH, cols);
        reg_write(REG_GRID_HEIGHT, rows);
        // Release the port after the last access cycle.
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_items(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            maybe_pause();
            offer_item(pick_item(), 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus one long hold on request.
    always @(posedge i_clk) begin
        if (hold_orders != holds_served) begin
            holds_served <= hold_orders;
            stall_left <= LONG_HOLD;
            result_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(0, 17);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest awaited report.
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (awaited_reports.size() == 0) begin
                $error("result beat with nothing awaited: cell_color %0d halted %0d",
                       result_ch.cell_color, result_ch.halted);
                mismatch_count++;
            end else begin
                want = awaited_reports.pop_front();
                if (result_ch.cell_color !== want.color) begin
                    $error("cell_color: expected %0d, got %0d", want.color,
                           result_ch.cell_color);
                    mismatch_count++;
                end
                if (result_ch.halted !== want.halted) begin
                    $error("halted: expected %0d, got %0d", want.halted, result_ch.halted);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_item it;
        t_report fixed_rep;
        int k;

        // Directed rows run under the reset configuration; ant 1 stays clear of the border.
        probe_rows = '{
            '{OP_READ,    9'd0,   8'd0,   8'd0,   HD_YINC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_PLACE,   9'd1,   8'd128, 8'd128, HD_YINC, 1'b1, 8'd0, 1'b0},
            '{OP_ADVANCE, 9'd0,   8'd0,   8'd0,   HD_YINC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd128, 8'd128, HD_YINC, 1'b1, 8'd1, 1'b0},
            '{OP_ADVANCE, 9'd511, 8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd127, 8'd128, HD_YINC, 1'b1, 8'd1, 1'b0},
            '{OP_PLACE,   9'd0,   8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_PLACE,   9'd511, 8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_NONE,    9'd511, 8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_PLACE,   9'd256, 8'd255, 8'd255, HD_XINC, 1'b1, 8'd0, 1'b0},
            '{OP_PLACE,   9'd2,   8'd0,   8'd255, HD_XDEC, 1'b1, 8'd0, 1'b0},
            '{OP_ADVANCE, 9'd0,   8'd0,   8'd0,   HD_YINC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd127, 8'd127, HD_YINC, 1'b0, 8'd0, 1'b0},
            '{OP_ADVANCE, 9'd0,   8'd0,   8'd0,   HD_YDEC, 1'b1, 8'd0, 1'b0},
            '{OP_ADVANCE, 9'd0,   8'd0,   8'd0,   HD_XDEC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd128, 8'd128, HD_YINC, 1'b0, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd0,   8'd255, HD_YINC, 1'b0, 8'd0, 1'b0},
            '{OP_PLACE,   9'd1,   8'd200, 8'd17,  HD_YDEC, 1'b1, 8'd0, 1'b0},
            '{OP_ADVANCE, 9'd0,   8'd0,   8'd0,   HD_YINC, 1'b1, 8'd0, 1'b0},
            '{OP_READ,    9'd0,   8'd200, 8'd17,  HD_YINC, 1'b0, 8'd0, 1'b0}
        };

        // Every input starts known while reset is held.
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.operation <= OP_NONE;
        item_ch.ant_number <= '0;
        item_ch.x_pos <= '0;
        item_ch.y_pos <= '0;
        item_ch.heading <= HD_YINC;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; the first beat waits out the cell clearing sweep.
        for (k = 0; k < PROBE_N; k++) begin
            maybe_pause();
            it.op = probe_rows[k].op;
            it.num = probe_rows[k].num;
            it.x = probe_rows[k].x;
            it.y = probe_rows[k].y;
            it.hd = probe_rows[k].hd;
            fixed_rep.color = probe_rows[k].color;
            fixed_rep.halted = probe_rows[k].halted;
            offer_item(it, probe_rows[k].fixed, fixed_rep);
        end

        // One cell shared by sixteen ants: colours wrap from 255 back to 0.
        configure(1'b0, 1'b1, 32'hFFFF_FFFF, 0, 16, 0, 0);
        random_items(40);

        // Multicolour rule on a small grid, with a full drain midway.
        configure(1'b0, 1'b1, $urandom, 3, 4, 16, 16);
        random_items(60);
        drain_results();
        random_items(60);

        // Rotating rule; the result side holds off while beats keep coming.
        configure(1'b1, 1'b1, $urandom, 7, 8, 12, 9);
        random_items(60);
        hold_orders++;
        random_items(60);

        // Every ant in play; ant 256 paints colour 0.
        configure(1'b1, 1'b1, $urandom, 1, 511, 511, 4);
        random_items(300);

        // A lone ant on the full grid, longest rule.
        configure(1'b0, 1'b1, $urandom, 63, 0, 256, 511);
        random_items(60);

        // All right turns on a tiny grid.
        configure(1'b0, 1'b1, 32'h0, 32, 5, 3, 2);
        random_items(60);

        // Border halts the grid; reads and placements go on afterwards.
        calm = 1'b1;
        configure(1'b0, 1'b0, $urandom, 5, 3, 6, 5);
        random_items(70);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
